### hdl/sevseg_pkg.sv
// Shared constants, types and character lookup for the scrolling seven-segment scanner.
package sevseg_pkg;

  localparam int unsigned MAX_LEN    = 64;
  localparam int unsigned MAX_DIGITS = 8;
  localparam int unsigned ADDR_W     = $clog2(MAX_LEN);
  localparam int unsigned LEN_W      = $clog2(MAX_LEN + 1);
  localparam int unsigned DIG_W      = $clog2(MAX_DIGITS);
  localparam int unsigned DCNT_W     = 4;
  localparam int unsigned DWELL_W    = 16;
  localparam int unsigned CODE_W     = 7;
  localparam int unsigned SEG_W      = 8;
  localparam int unsigned APB_AW     = 4;
  localparam int unsigned APB_DW     = 32;

  localparam logic [CODE_W-1:0] CODE_BLANK = CODE_W'(" ");
  localparam logic [CODE_W-1:0] CODE_FOLD  = CODE_W'(96);
  localparam logic [CODE_W-1:0] CASE_DIFF  = CODE_W'(32);
  localparam logic [SEG_W-1:0]  SEG_NONE   = 8'hff;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_TICK    = 2'd1,
    OP_RESTART = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    REG_DIGIT_COUNT = 2'd0,
    REG_DWELL_TICKS = 2'd1,
    REG_ONE_SHOT    = 2'd2,
    REG_MSG_LENGTH  = 2'd3
  } cfg_reg_e;

  // Segment patterns for codes 32..95.
  localparam logic [SEG_W-1:0] SEG_TABLE [64] = '{
    8'h00, 8'h86, 8'h22, 8'hff, 8'hff, 8'hff, 8'hff, 8'h20,
    8'h39, 8'h0f, 8'hff, 8'hff, 8'h04, 8'h40, 8'h80, 8'h52,
    8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07,
    8'h7f, 8'h6f, 8'hc2, 8'h82, 8'h61, 8'h48, 8'h43, 8'hd3,
    8'hff, 8'h77, 8'h7c, 8'h39, 8'h5e, 8'h79, 8'h71, 8'h3d,
    8'h74, 8'h30, 8'h1e, 8'h75, 8'h38, 8'h15, 8'h37, 8'h5c,
    8'h73, 8'h67, 8'h33, 8'h69, 8'h78, 8'h3e, 8'h2e, 8'h2a,
    8'h76, 8'h6e, 8'h4b, 8'hff, 8'h64, 8'hff, 8'hff, 8'h08
  };

  // Codes 32..95 have bits [6:5] equal to 01 or 10.
  function automatic logic [SEG_W-1:0] seg_lookup(input logic [CODE_W-1:0] code);
    logic [5:0] idx;
    idx = {code[6], code[4:0]};
    if (code[6] == code[5]) begin
      return SEG_NONE;
    end
    return SEG_TABLE[idx];
  endfunction

  // Bit i set where i is a multiple of step, for i in 0..63.
  function automatic logic [63:0] mult_mask(input int unsigned step);
    logic [63:0] m;
    int unsigned i;
    m = '0;
    i = 0;
    while (i < 64) begin
      m[i] = 1'b1;
      i = i + step;
    end
    return m;
  endfunction

  localparam logic [63:0] MASK3 = mult_mask(3);
  localparam logic [63:0] MASK5 = mult_mask(5);
  localparam logic [63:0] MASK7 = mult_mask(7);

  // 4 = 1 mod 3: sum base-4 digits.
  function automatic logic div_by3(input logic [DWELL_W-1:0] v);
    logic [5:0] s;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + {4'b0, v[2*i +: 2]};
    end
    return MASK3[s];
  endfunction

  // 16 = 1 mod 5: sum base-16 digits.
  function automatic logic div_by5(input logic [DWELL_W-1:0] v);
    logic [5:0] s;
    s = '0;
    for (int i = 0; i < 4; i++) begin
      s = s + {2'b0, v[4*i +: 4]};
    end
    return MASK5[s];
  endfunction

  // 8 = 1 mod 7: sum base-8 digits.
  function automatic logic div_by7(input logic [DWELL_W-1:0] v);
    logic [5:0] s;
    s = {5'b0, v[15]};
    for (int i = 0; i < 5; i++) begin
      s = s + {3'b0, v[3*i +: 3]};
    end
    return MASK7[s];
  endfunction

endpackage

### hdl/sevseg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sevseg_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/scrolling_seven_segment_scanner.sv
// Top level: scrolling message scanner for a multiplexed seven-segment row.
//
//   channel  direction  handshake                fields
//   in       sink       in_valid_i / in_ready_o  op_i, char_code_i, char_index_i
//   out      source     out_valid_o / out_ready_i digit_index_o, segments_o, pass_end_o
//   cfg      APB        psel/penable/pwrite      paddr, pwdata, prdata
//
// One item per cycle unless out_ready_i stalls the output. A tick is decoded in the
// accept cycle, which issues the message RAM read; the lookup stage then maps the
// character to segments, and the output register takes the result once it is free.
// No clearing pass: reset only clears control registers, the RAM is never cleared.
// in_ready_o drops only while both the lookup stage and the output register hold results.
module scrolling_seven_segment_scanner (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [1:0]                            op_i,
  input  logic [sevseg_pkg::CODE_W-1:0]         char_code_i,
  input  logic [sevseg_pkg::ADDR_W-1:0]         char_index_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [sevseg_pkg::DIG_W-1:0]          digit_index_o,
  output logic [sevseg_pkg::SEG_W-1:0]          segments_o,
  output logic                                  pass_end_o,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [sevseg_pkg::APB_AW-1:0]         paddr,
  input  logic [sevseg_pkg::APB_DW-1:0]         pwdata,
  output logic [sevseg_pkg::APB_DW-1:0]         prdata,
  output logic                                  pready
);

  import sevseg_pkg::*;

  // Configuration registers
  logic [DCNT_W-1:0]  dcnt_q;
  logic [DWELL_W-1:0] dwell_q;
  logic               one_shot_q;
  logic [LEN_W-1:0]   msg_len_q;
  logic               div3_q, div5_q, div7_q;

  // Scan state
  logic [LEN_W-1:0]   ws_q;
  logic [DWELL_W-1:0] tick_q;
  logic [DIG_W-1:0]   dpos_q;
  logic               running_q;
  logic [DIG_W-1:0]   last_digit_q;
  logic [SEG_W-1:0]   last_seg_q;

  // Lookup stage and output register
  logic               s1_valid_q;
  logic               s1_pass_q;
  logic               s1_blank_q;
  logic [DIG_W-1:0]   s1_digit_q;
  logic               out_valid_q;
  logic [DIG_W-1:0]   out_digit_q;
  logic [SEG_W-1:0]   out_seg_q;
  logic               out_pass_q;

  logic               cfg_wr;
  cfg_reg_e           cfg_idx;
  logic               in_acc;
  op_e                op;
  logic               out_free;
  logic               s1_move;
  logic [3:0]         d_eff;
  logic [LEN_W-1:0]   len_eff;
  logic [DIG_W-1:0]   dpos_eff;
  logic [7:0]         last_pos;
  logic               tick_nz;
  logic               pass_hit;
  logic               div_ok;
  logic               step;
  logic [LEN_W-1:0]   ws_step;
  logic [DWELL_W-1:0] tick_base;
  logic [DWELL_W-1:0] tick_next;
  logic [7:0]         pos;
  logic [7:0]         dm1;
  logic [7:0]         rel;
  logic               in_msg;
  logic [DIG_W-1:0]   dpos_next;
  logic               tick_res;
  logic               ram_we;
  logic [CODE_W-1:0]  load_code;
  logic               ram_re;
  logic [CODE_W-1:0]  ram_rdata;
  logic [SEG_W-1:0]   s1_seg;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_idx = cfg_reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_DIGIT_COUNT: prdata = {{(APB_DW-DCNT_W){1'b0}}, dcnt_q};
      REG_DWELL_TICKS: prdata = {{(APB_DW-DWELL_W){1'b0}}, dwell_q};
      REG_ONE_SHOT:    prdata = {{(APB_DW-1){1'b0}}, one_shot_q};
      REG_MSG_LENGTH:  prdata = {{(APB_DW-LEN_W){1'b0}}, msg_len_q};
      default:         prdata = '0;
    endcase
  end

  // Divisibility of the dwell by 3, 5 and 7 is captured with each dwell write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q     <= DCNT_W'(4);
      dwell_q    <= DWELL_W'(1000);
      one_shot_q <= 1'b1;
      msg_len_q  <= '0;
      div3_q     <= div_by3(DWELL_W'(1000));
      div5_q     <= div_by5(DWELL_W'(1000));
      div7_q     <= div_by7(DWELL_W'(1000));
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DIGIT_COUNT: dcnt_q <= pwdata[DCNT_W-1:0];
        REG_DWELL_TICKS: begin
          dwell_q <= pwdata[DWELL_W-1:0];
          div3_q  <= div_by3(pwdata[DWELL_W-1:0]);
          div5_q  <= div_by5(pwdata[DWELL_W-1:0]);
          div7_q  <= div_by7(pwdata[DWELL_W-1:0]);
        end
        REG_ONE_SHOT:    one_shot_q <= pwdata[0];
        REG_MSG_LENGTH:  msg_len_q  <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- handshake ----------------
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || s1_move;
  assign in_acc     = in_valid_i && in_ready_o;
  assign op         = op_e'(op_i);

  // ---------------- tick decode ----------------
  always_comb begin
    if (dcnt_q == '0) begin
      d_eff = 4'd1;
    end else if (dcnt_q > 4'(MAX_DIGITS)) begin
      d_eff = 4'(MAX_DIGITS);
    end else begin
      d_eff = dcnt_q;
    end
  end

  assign len_eff  = (msg_len_q > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : msg_len_q;
  assign dpos_eff = ({1'b0, dpos_q} >= d_eff) ? '0 : dpos_q;
  assign dm1      = {4'b0, d_eff} - 8'd1;
  assign last_pos = {1'b0, len_eff} + dm1;
  assign tick_nz  = (tick_q != '0);
  assign pass_hit = (dpos_eff == '0) && tick_nz && ({1'b0, ws_q} >= last_pos);

  always_comb begin
    case (d_eff)
      4'd1:    div_ok = 1'b1;
      4'd2:    div_ok = !dwell_q[0];
      4'd3:    div_ok = div3_q;
      4'd4:    div_ok = (dwell_q[1:0] == 2'b00);
      4'd5:    div_ok = div5_q;
      4'd6:    div_ok = div3_q && !dwell_q[0];
      4'd7:    div_ok = div7_q;
      4'd8:    div_ok = (dwell_q[2:0] == 3'b000);
      default: div_ok = 1'b0;
    endcase
  end

  // Step once the dwell has elapsed at the first digit and is a multiple of d_eff.
  assign step      = (dpos_eff == '0) && tick_nz && (tick_q == dwell_q) && div_ok;
  assign ws_step   = step ? ws_q + LEN_W'(1) : ws_q;
  assign tick_base = step ? '0 : tick_q;
  assign tick_next = (&tick_base) ? tick_base : tick_base + DWELL_W'(1);
  assign dpos_next = ({1'b0, dpos_eff} + 4'd1 == d_eff) ? '0 : dpos_eff + DIG_W'(1);

  // Padded position: leading blanks, then the message, then trailing blanks.
  assign pos    = {1'b0, ws_step} + {5'b0, dpos_eff};
  assign rel    = pos - dm1;
  assign in_msg = (pos >= dm1) && (rel < {1'b0, len_eff});

  assign tick_res = in_acc && (op == OP_TICK) && running_q && (len_eff != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q         <= '0;
      tick_q       <= '0;
      dpos_q       <= '0;
      running_q    <= 1'b0;
      last_digit_q <= '0;
    end else if (in_acc) begin
      case (op)
        OP_RESTART: begin
          ws_q      <= '0;
          tick_q    <= '0;
          dpos_q    <= '0;
          running_q <= 1'b1;
        end
        OP_TICK: begin
          if (tick_res) begin
            if (pass_hit) begin
              ws_q   <= '0;
              tick_q <= '0;
              dpos_q <= '0;
              if (one_shot_q) begin
                running_q <= 1'b0;
              end
            end else begin
              ws_q         <= ws_step;
              tick_q       <= tick_next;
              dpos_q       <= dpos_next;
              last_digit_q <= dpos_eff;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------- message store ----------------
  assign ram_we    = in_acc && (op == OP_LOAD);
  assign load_code = (char_code_i > CODE_FOLD) ? char_code_i - CASE_DIFF : char_code_i;
  assign ram_re    = tick_res && !pass_hit;

  sevseg_ram #(
    .Width (CODE_W),
    .Depth (MAX_LEN)
  ) u_msg_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (char_index_i),
    .wdata_i (load_code),
    .re_i    (ram_re),
    .raddr_i (rel[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // ---------------- lookup stage ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= tick_res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_res) begin
      s1_pass_q  <= pass_hit;
      s1_blank_q <= !in_msg;
      s1_digit_q <= pass_hit ? last_digit_q : dpos_eff;
    end
  end

  // A pass end repeats the segments of the last shown digit.
  assign s1_seg = s1_pass_q  ? last_seg_q :
                  s1_blank_q ? seg_lookup(CODE_BLANK) : seg_lookup(ram_rdata);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_seg_q <= '0;
    end else if (s1_move && !s1_pass_q) begin
      last_seg_q <= s1_seg;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_digit_q <= s1_digit_q;
      out_seg_q   <= s1_seg;
      out_pass_q  <= s1_pass_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign digit_index_o = out_digit_q;
  assign segments_o    = out_seg_q;
  assign pass_end_o    = out_pass_q;

`ifndef NO_ASSERTIONS
  // A held lookup result must stay until the output register takes it.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_free |=> s1_valid_q)
    else $error("lookup stage dropped a result");

  // A RAM read always fills the lookup stage on the next cycle.
  a_read_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |=> s1_valid_q && !s1_pass_q)
    else $error("RAM read without a lookup entry");

  // Input backpressure only when both result slots are occupied.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled with a free slot");

  // A pass end returns the scan to its start.
  a_pass_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_res && pass_hit |=> ws_q == '0 && tick_q == '0 && dpos_q == '0)
    else $error("scan state not cleared at pass end");
`endif

endmodule
